// ----- design/ccp_pkg.sv -----
// shared types and constants for the circle-circle penetration block
package ccp_pkg;

    localparam int CW     = 24;        // coordinate width
    localparam int DW     = CW + 2;    // centre difference width
    localparam int AW     = CW - 1;    // magnitude of a difference that can still touch
    localparam int RW     = CW - 2;    // radius width
    localparam int SW     = CW - 1;    // radius sum width
    localparam int MW     = 2 * CW;    // squared distance, padded to an even width
    localparam int PW     = AW + SW;   // dividend width
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic signed [CW-1:0] a_x;
        logic signed [CW-1:0] a_y;
        logic signed [CW-1:0] shift_x;
        logic signed [CW-1:0] shift_y;
        logic signed [CW-1:0] b_x;
        logic signed [CW-1:0] b_y;
        logic [RW-1:0]        radius_a;
        logic [RW-1:0]        radius_b;
    } t_req;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] push_x;
        logic signed [CW-1:0] push_y;
    } t_res;

    // classified request handed from front to back
    typedef struct packed {
        logic          hit;
        logic          live;
        logic          pos_x;
        logic          pos_y;
        logic [AW-1:0] adx;
        logic [AW-1:0] ady;
        logic [SW-1:0] rsum;
        logic [MW-1:0] mag;
    } t_cls;

    typedef struct packed {
        logic hit;
        logic live;
        logic pos_x;
        logic pos_y;
    } t_flag;

endpackage

// ----- design/circle_circle_penetration_top.sv -----
// top level of the circle-circle penetration block
//
// request channel: i_valid / o_ready with i_req (centres, trial shift, radii)
// result channel:  o_valid / i_ready with o_res (hit flag and push-out vector)
//
// a request is taken on every edge with i_valid and o_ready high; one
// request per cycle is sustained while the result side keeps taking
// results
// pipeline: the front stages (difference, squares, contact test), the
// queue, then 24 square-root stages, one product stage, one divider
// set-up stage, 24 divider stages and the output register; the
// square-root and divider stage counts follow the coordinate width
// the front and the back each stall as a whole; the queue of four requests
// between them lets the front keep taking requests while the back waits
// on the receiver, and the back keep draining while the front is empty
// reset clears every valid flag and the queue; no result is pending after it
// when i_ready is low the finished result holds in the output register
module circle_circle_penetration_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ccp_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output ccp_pkg::t_res o_res
);
    import ccp_pkg::*;

    // front to queue
    logic f_valid, f_ready;
    t_cls f_cls;
    // queue to back
    logic q_valid, q_ready;
    t_cls q_cls;

    ccp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_cls   (f_cls)
    );

    ccp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_cls   (f_cls),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_cls   (q_cls)
    );

    // back end: square root, penetration and divide, result register
    ccp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_cls   (q_cls),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (o_res)
    );

endmodule

// ----- design/ccp_front.sv -----
// front end: centre difference, squared distance and contact test
module ccp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ccp_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output ccp_pkg::t_cls o_cls
);
    import ccp_pkg::*;

    logic                 en;
    logic                 r_v1, r_v2, r_v3;
    logic signed [DW-1:0] n_dx, n_dy, r_dx, r_dy;
    logic [SW-1:0]        r1_rsum, r2_rsum;
    logic [DW-1:0]        absx, absy;
    logic                 r_far, r_posx, r_posy;
    logic [AW-1:0]        r_adx, r_ady;
    logic [2*AW-1:0]      r_sqx, r_sqy;
    logic [2*SW-1:0]      r_rs2;
    logic [MW-1:0]        mag;
    logic                 hit;
    t_cls                 r_cls;

    assign en      = !r_v3 || i_ready;
    assign o_ready = en;
    assign o_valid = r_v3;
    assign o_cls   = r_cls;

    assign n_dx = DW'(i_req.b_x) - DW'(i_req.a_x) - DW'(i_req.shift_x);
    assign n_dy = DW'(i_req.b_y) - DW'(i_req.a_y) - DW'(i_req.shift_y);

    assign absx = r_dx[DW-1] ? DW'(-r_dx) : DW'(r_dx);
    assign absy = r_dy[DW-1] ? DW'(-r_dy) : DW'(r_dy);

    assign mag = MW'(r_sqx) + MW'(r_sqy);
    assign hit = !r_far && (mag < MW'(r_rs2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx    <= n_dx;
            r_dy    <= n_dy;
            r1_rsum <= SW'(i_req.radius_a) + SW'(i_req.radius_b);
            // too far on either axis means no contact is possible
            r_far   <= (|absx[DW-1:AW]) || (|absy[DW-1:AW]);
            r_posx  <= !r_dx[DW-1] && (r_dx != '0);
            r_posy  <= !r_dy[DW-1] && (r_dy != '0);
            r_adx   <= absx[AW-1:0];
            r_ady   <= absy[AW-1:0];
            r_sqx   <= absx[AW-1:0] * absx[AW-1:0];
            r_sqy   <= absy[AW-1:0] * absy[AW-1:0];
            r_rs2   <= r1_rsum * r1_rsum;
            r2_rsum <= r1_rsum;
            r_cls.hit   <= hit;
            r_cls.live  <= hit && (mag != '0);
            r_cls.pos_x <= r_posx;
            r_cls.pos_y <= r_posy;
            r_cls.adx   <= r_adx;
            r_cls.ady   <= r_ady;
            r_cls.rsum  <= r2_rsum;
            r_cls.mag   <= mag;
        end
    end

endmodule

// ----- design/ccp_queue.sv -----
// short queue of classified requests between front and back
module ccp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ccp_pkg::t_cls i_cls,
    output logic          o_valid,
    input  logic          i_ready,
    output ccp_pkg::t_cls o_cls
);
    import ccp_pkg::*;

    t_cls         r_mem [QDEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QAW:0]   r_cnt;
    logic           push, pop;

    assign o_ready = (r_cnt != QAW'(0) + (QAW+1)'(QDEPTH)) ;
    assign o_valid = (r_cnt != '0);
    assign o_cls   = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_cls;
    end

endmodule

// ----- design/ccp_back.sv -----
// back end: pipelined square root, penetration product and division
module ccp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  ccp_pkg::t_cls i_cls,
    output logic          o_valid,
    input  logic          i_ready,
    output ccp_pkg::t_res o_res
);
    import ccp_pkg::*;

    logic          adv;
    // square root stages
    logic          r_sv   [CW];
    t_cls          r_sc   [CW];
    logic [CW:0]   r_rem  [CW];
    logic [CW-1:0] r_root [CW];
    // product stage
    logic          r_mv;
    t_flag         r_mf;
    logic [CW-1:0] r_mdist;
    logic [PW-1:0] r_mpx, r_mpy;
    logic [SW-1:0] pen;
    // division set-up stage
    logic          r_iv;
    t_flag         r_if;
    logic [CW-1:0] r_idist;
    logic [PW-1:0] r_ipx, r_ipy;
    logic          r_iox, r_ioy;
    // division stages
    logic          r_dv   [CW];
    t_flag         r_df   [CW];
    logic [CW-1:0] r_dd   [CW];
    logic [PW-1:0] r_dpx  [CW];
    logic [PW-1:0] r_dpy  [CW];
    logic [CW-1:0] r_drx  [CW];
    logic [CW-1:0] r_dry  [CW];
    logic [CW-1:0] r_dqx  [CW];
    logic [CW-1:0] r_dqy  [CW];
    logic          r_dox  [CW];
    logic          r_doy  [CW];
    // output
    logic          r_ov;
    t_res          r_res;

    function automatic logic [CW-1:0] f_sat(input logic pos, input logic ovf,
                                            input logic [CW-1:0] q);
        logic [CW-1:0] lim;
        lim = {1'b1, {(CW-1){1'b0}}};
        if (pos) begin
            f_sat = (ovf || q > lim) ? lim : CW'(-q);
        end else begin
            f_sat = (ovf || q > lim - 1'b1) ? lim - 1'b1 : q;
        end
    endfunction

    assign adv     = !r_ov || i_ready;
    assign o_ready = adv;
    assign o_valid = r_ov;
    assign o_res   = r_res;

    for (genvar k = 0; k < CW; k++) begin : g_sq
        logic          pv;
        t_cls          pc;
        logic [CW:0]   prem;
        logic [CW-1:0] proot;
        logic [CW+2:0] cur, trial, diff;
        logic          ge;
        if (k == 0) begin : g_first
            assign pv    = i_valid;
            assign pc    = i_cls;
            assign prem  = '0;
            assign proot = '0;
        end else begin : g_next
            assign pv    = r_sv[k-1];
            assign pc    = r_sc[k-1];
            assign prem  = r_rem[k-1];
            assign proot = r_root[k-1];
        end
        assign cur   = {prem, pc.mag[2*(CW-1-k)+1 -: 2]};
        assign trial = {1'b0, proot, 2'b01};
        assign diff  = cur - trial;
        assign ge    = cur >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k] <= 1'b0;
            end else if (adv) begin
                r_sv[k] <= pv;
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_sc[k]   <= pc;
                r_rem[k]  <= ge ? diff[CW:0] : cur[CW:0];
                r_root[k] <= {proot[CW-2:0], ge};
            end
        end
    end

    // dist is below rsum on a live hit, so it fits the radius-sum width
    assign pen = r_sc[CW-1].rsum - r_root[CW-1][SW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
            r_iv <= 1'b0;
        end else if (adv) begin
            r_mv <= r_sv[CW-1];
            r_iv <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mf.hit   <= r_sc[CW-1].hit;
            r_mf.live  <= r_sc[CW-1].live;
            r_mf.pos_x <= r_sc[CW-1].pos_x;
            r_mf.pos_y <= r_sc[CW-1].pos_y;
            r_mdist    <= r_root[CW-1];
            r_mpx      <= r_sc[CW-1].adx * pen;
            r_mpy      <= r_sc[CW-1].ady * pen;
            r_if       <= r_mf;
            r_idist    <= r_mdist;
            r_ipx      <= r_mpx;
            r_ipy      <= r_mpy;
            // quotient would not fit the coordinate width
            r_iox      <= CW'(r_mpx[PW-1:CW]) >= r_mdist;
            r_ioy      <= CW'(r_mpy[PW-1:CW]) >= r_mdist;
        end
    end

    for (genvar k = 0; k < CW; k++) begin : g_div
        logic          pv;
        t_flag         pf;
        logic [CW-1:0] pd, prx, pry, pqx, pqy;
        logic [PW-1:0] ppx, ppy;
        logic          pox, poy;
        logic [CW:0]   curx, cury, difx, dify;
        logic          gex, gey;
        if (k == 0) begin : g_first
            assign pv  = r_iv;
            assign pf  = r_if;
            assign pd  = r_idist;
            assign ppx = r_ipx;
            assign ppy = r_ipy;
            assign prx = CW'(r_ipx[PW-1:CW]);
            assign pry = CW'(r_ipy[PW-1:CW]);
            assign pqx = '0;
            assign pqy = '0;
            assign pox = r_iox;
            assign poy = r_ioy;
        end else begin : g_next
            assign pv  = r_dv[k-1];
            assign pf  = r_df[k-1];
            assign pd  = r_dd[k-1];
            assign ppx = r_dpx[k-1];
            assign ppy = r_dpy[k-1];
            assign prx = r_drx[k-1];
            assign pry = r_dry[k-1];
            assign pqx = r_dqx[k-1];
            assign pqy = r_dqy[k-1];
            assign pox = r_dox[k-1];
            assign poy = r_doy[k-1];
        end
        assign curx = {prx, ppx[CW-1-k]};
        assign cury = {pry, ppy[CW-1-k]};
        assign gex  = curx >= {1'b0, pd};
        assign gey  = cury >= {1'b0, pd};
        assign difx = curx - {1'b0, pd};
        assign dify = cury - {1'b0, pd};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k] <= 1'b0;
            end else if (adv) begin
                r_dv[k] <= pv;
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_df[k]  <= pf;
                r_dd[k]  <= pd;
                r_dpx[k] <= ppx;
                r_dpy[k] <= ppy;
                r_drx[k] <= gex ? difx[CW-1:0] : curx[CW-1:0];
                r_dry[k] <= gey ? dify[CW-1:0] : cury[CW-1:0];
                r_dqx[k] <= {pqx[CW-2:0], gex};
                r_dqy[k] <= {pqy[CW-2:0], gey};
                r_dox[k] <= pox;
                r_doy[k] <= poy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_dv[CW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res.hit    <= r_df[CW-1].hit;
            r_res.push_x <= r_df[CW-1].live
                ? f_sat(r_df[CW-1].pos_x, r_dox[CW-1], r_dqx[CW-1]) : '0;
            r_res.push_y <= r_df[CW-1].live
                ? f_sat(r_df[CW-1].pos_y, r_doy[CW-1], r_dqy[CW-1]) : '0;
        end
    end

endmodule

// ----- sim/circle_circle_penetration_checker.sv -----
// checker for the circle-circle penetration block: predicts push-out results and compares
module circle_circle_penetration_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_ready_in,
    input  ccp_pkg::t_req  i_req,
    input  logic           i_valid_out,
    input  logic           i_ready,
    input  ccp_pkg::t_res  i_res,
    output int             o_fail_count,
    output int             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ccp_pkg::*;

    t_res expected_pushes[$];

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic signed [CW-1:0] push_axis(input longint d,
            input longint unsigned pen, input longint unsigned root_len);
        longint unsigned q;
        longint unsigned mag;
        mag = (d < 0) ? longint'(-d) : longint'(d);
        q   = mag * pen / root_len;
        if (d > 0) begin
            if (q > (64'd1 << (CW-1))) q = 64'd1 << (CW-1);
            return CW'(-q);
        end
        if (q > (64'd1 << (CW-1)) - 1) q = (64'd1 << (CW-1)) - 1;
        return CW'(q);
    endfunction

    function automatic t_res predict_push(input t_req r);
        t_res o;
        longint dx;
        longint dy;
        longint unsigned adx;
        longint unsigned ady;
        longint unsigned rsum;
        longint unsigned mag;
        longint unsigned root_len;
        o  = '0;
        dx = longint'(r.b_x) - (longint'(r.a_x) + longint'(r.shift_x));
        dy = longint'(r.b_y) - (longint'(r.a_y) + longint'(r.shift_y));
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        rsum = longint'(r.radius_a) + longint'(r.radius_b);
        // far apart: no contact possible
        if (adx >= (64'd1 << (CW-1)) || ady >= (64'd1 << (CW-1))) return o;
        mag = adx * adx + ady * ady;
        if (!(mag < rsum * rsum)) return o;
        o.hit = 1'b1;
        root_len = int_sqrt(mag);
        // coincident centres give a zero push
        if (root_len == 0) return o;
        o.push_x = push_axis(dx, rsum - root_len, root_len);
        o.push_y = push_axis(dy, rsum - root_len, root_len);
        return o;
    endfunction

    assign o_pending = expected_pushes.size();

    always @(posedge i_clk) begin
        t_res exp_r;
        if (!i_rst_n) begin
            o_fail_count = 0;
        end else begin
            if (i_valid && i_ready_in) expected_pushes.push_back(predict_push(i_req));
            if (i_valid_out && i_ready) begin
                if (expected_pushes.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) $display("unexpected result %p", i_res);
                end else begin
                    exp_r = expected_pushes.pop_front();
                    if (exp_r.hit !== i_res.hit || exp_r.push_x !== i_res.push_x
                            || exp_r.push_y !== i_res.push_y) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: expected %p got %p", exp_r, i_res);
                    end
                end
            end
        end
    end
endmodule

// ----- sim/circle_circle_penetration_top_tb.sv -----
// testbench top for the circle-circle penetration block: stimulus and verdict
module circle_circle_penetration_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ccp_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    t_req i_req = '0;
    logic o_ready;
    logic o_valid;
    t_res o_res;
    int fail_count;
    int pending;
    int idle_pct = 0;      // sender idle chance
    int stall_pct = 0;     // receiver stall chance
    int hold_off = 0;      // long receiver hold-off, in cycles
    longint cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    circle_circle_penetration_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_req(i_req), .o_valid(o_valid), .i_ready(i_ready), .o_res(o_res)
    );

    circle_circle_penetration_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_ready_in(o_ready),
        .i_req(i_req), .i_valid_out(o_valid), .i_ready(i_ready), .i_res(o_res),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready  <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic signed [CW-1:0] rand_coord(input int span);
        case ($urandom_range(5))
            0: return CW'($urandom);
            1: return {1'b0, {(CW-1){1'b1}}};
            2: return {1'b1, {(CW-1){1'b0}}};
            default: return CW'($signed($urandom_range(2 * span)) - span);
        endcase
    endfunction

    // mostly near pairs so that contact is frequent, with some wide noise
    function automatic t_req rand_pair();
        t_req r;
        int span;
        span = ($urandom_range(3) == 0) ? 8000000 : 30000;
        r.a_x = rand_coord(span);
        r.a_y = rand_coord(span);
        r.shift_x = $urandom_range(1) ? CW'($signed($urandom_range(2000)) - 1000)
                                      : rand_coord(span);
        r.shift_y = $urandom_range(1) ? CW'($signed($urandom_range(2000)) - 1000)
                                      : rand_coord(span);
        r.b_x = $urandom_range(2) ? r.a_x + CW'($signed($urandom_range(40000)) - 20000)
                                  : rand_coord(span);
        r.b_y = $urandom_range(2) ? r.a_y + CW'($signed($urandom_range(40000)) - 20000)
                                  : rand_coord(span);
        r.radius_a = ($urandom_range(7) == 0) ? RW'($urandom) : RW'($urandom_range(30000));
        r.radius_b = ($urandom_range(7) == 0) ? RW'($urandom) : RW'($urandom_range(30000));
        return r;
    endfunction

    // valid drops only while the sender idles or drains
    task automatic send_request(input t_req r);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    t_req dir_req[$];
    t_req r;

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: coincident centres, just touching, far apart, extremes
        r = '0; r.radius_a = RW'(4096); dir_req.push_back(r);
        r = '0; dir_req.push_back(r);
        r = '0; r.b_x = CW'(8192); r.radius_a = RW'(4096); r.radius_b = RW'(4096);
        dir_req.push_back(r);
        r = '0; r.b_x = CW'(8191); r.radius_a = RW'(4096); r.radius_b = RW'(4096);
        dir_req.push_back(r);
        r = '0; r.b_y = CW'(-8191); r.radius_a = RW'(4096); r.radius_b = RW'(4096);
        dir_req.push_back(r);
        r = '0; r.b_x = CW'(3); r.b_y = CW'(-4); r.radius_a = '1; r.radius_b = '1;
        dir_req.push_back(r);
        r = '0; r.b_x = CW'(-3); r.b_y = CW'(4); r.radius_a = '1; r.radius_b = '1;
        dir_req.push_back(r);
        r = '0; r.a_x = {1'b1, {(CW-1){1'b0}}}; r.shift_x = {1'b1, {(CW-1){1'b0}}};
        r.b_x = {1'b0, {(CW-1){1'b1}}}; r.radius_a = '1; r.radius_b = '1;
        dir_req.push_back(r);
        r = '0; r.a_x = {1'b0, {(CW-1){1'b1}}}; r.shift_x = {1'b0, {(CW-1){1'b1}}};
        r.b_x = {1'b1, {(CW-1){1'b0}}}; dir_req.push_back(r);
        r = '0; r.b_x = {1'b0, {(CW-1){1'b1}}}; r.radius_a = '1; r.radius_b = '1;
        dir_req.push_back(r);
        r = '0; r.b_x = CW'(-(1 << 22)); r.b_y = CW'(1 << 22); r.radius_a = '1;
        r.radius_b = '1;
        dir_req.push_back(r);
        r = '1; dir_req.push_back(r);
        r = '0; r.a_y = CW'(-1); r.shift_y = CW'(-1); r.b_y = CW'(5); r.radius_b = RW'(100);
        dir_req.push_back(r);
        foreach (dir_req[k]) send_request(dir_req[k]);
        drain_results();

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1) ? 80 : (ph == 3) ? 28 : 0;
            stall_pct = (ph == 2) ? 80 : (ph == 3) ? 28 : 0;
            for (int n = 0; n < 450; n++) begin
                // long hold-off on the receiver so the queue fills
                if (ph == 0 && n == 100) hold_off = 300;
                send_request(rand_pair());
                // sender pauses until every result is back
                if (ph == 1 && n == 200) drain_results();
            end
        end
        stall_pct = 0;
        for (int n = 0; n < 80; n++) send_request(rand_pair());
        drain_results();

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
